[rtl/core/torus_point_normal_eval_unit_assert.svh]
// Assertion macros for the torus point/normal evaluator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef TORUS_POINT_NORMAL_EVAL_UNIT_ASSERT_SVH
`define TORUS_POINT_NORMAL_EVAL_UNIT_ASSERT_SVH
// same-cycle implication
`define TPNE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define TPNE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/tpne_pkg.sv]
// Shared types, widths and constants of the torus point/normal evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tpne_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SCW  = 34;   // sin/cos Q30 with headroom
  localparam int RW   = 33;   // r*cos v, r*sin v
  localparam int RHW  = 34;   // rho
  localparam int PW   = 35;   // local point, h*cos u, h*sin u
  localparam int XW   = 70;   // gradient cross products
  localparam int NW   = 42;   // raw normal
  localparam int MW   = 60;   // rotated normal
  localparam int SUMW = 62;   // sum of squares
  localparam int SQRT_STEPS = 31;
  localparam int QBITS = 15;
  localparam int DIVW  = 46;
  localparam int NORM_MSB = 29;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam logic [29:0] MAJOR_RST = 30'd65536;
  localparam logic [29:0] MINOR_RST = 30'd16384;
  localparam logic [63:0] ROW_X_RST = 64'h0000_0000_0000_4000;
  localparam logic [63:0] ROW_Y_RST = 64'h0000_0000_4000_0000;
  localparam logic [63:0] ROW_Z_RST = 64'h0000_4000_0000_0000;

  typedef enum logic [2:0] {
    CFG_MAJOR, CFG_MINOR, CFG_ROW_X, CFG_ROW_Y, CFG_ROW_Z, CFG_NORM_EN
  } cfg_idx_t;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  // data that rides along with the normal through the normalizer
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               sat;
    logic               nvalid;
  } tpne_side_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] a;
    case (i)
      0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;
      3: a = 32'h051111D4;  4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;
      6: a = 32'h00A2F61E;  7: a = 32'h00517C55;  8: a = 32'h0028BE53;
      9: a = 32'h00145F2F;  10: a = 32'h000A2F98; 11: a = 32'h000517CC;
      12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2FA;
      15: a = 32'h0000517D; 16: a = 32'h000028BE; 17: a = 32'h0000145F;
      18: a = 32'h00000A30; 19: a = 32'h00000518; 20: a = 32'h0000028C;
      21: a = 32'h00000146; 22: a = 32'h000000A3; 23: a = 32'h00000051;
      24: a = 32'h00000029; 25: a = 32'h00000014; 26: a = 32'h0000000A;
      27: a = 32'h00000005; 28: a = 32'h00000003; 29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] coef(input logic [63:0] row, input int unsigned j);
    return $signed(row[j*16 +: 16]);
  endfunction

endpackage
`default_nettype wire

[rtl/core/tpne_cordic.sv]
// Pipelined rotation CORDIC: binary angle in, sin and cos in Q30 out.
// One iteration per stage, ANGLE_BITS+4 register levels; uses tpne_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpne_cordic
  import tpne_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [15:0]           angle,
  output logic signed [SCW-1:0]      sin_r,
  output logic signed [SCW-1:0]      cos_r
);

  localparam int STEPS = ANGLE_BITS + 2;
  localparam logic [31:0] KEEP = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

  logic [31:0]           phase;
  logic signed [SCW-1:0] x_r [0:STEPS];
  logic signed [SCW-1:0] y_r [0:STEPS];
  logic signed [31:0]    z_r [0:STEPS];
  quad_t                 q_r [0:STEPS];
  logic signed [SCW-1:0] sin_nxt, cos_nxt;

  assign phase = {angle, 16'h0000} & KEEP;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= SCW'(CORDIC_GAIN_Q30);
      y_r[0] <= '0;
      z_r[0] <= {2'b00, phase[29:0]};
      q_r[0] <= quad_t'(phase[31:30]);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [31:0] ATN = atan_turn(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][31]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATN;
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  always_comb begin
    case (q_r[STEPS])
      QUAD_0: begin cos_nxt = x_r[STEPS];  sin_nxt = y_r[STEPS];  end
      QUAD_1: begin cos_nxt = -y_r[STEPS]; sin_nxt = x_r[STEPS];  end
      QUAD_2: begin cos_nxt = -x_r[STEPS]; sin_nxt = -y_r[STEPS]; end
      default: begin cos_nxt = y_r[STEPS]; sin_nxt = -x_r[STEPS]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/tpne_norm.sv]
// Normal normalizer: pipelined integer square root, then three pipelined
// restoring dividers for 16384*m/len. Uses tpne_pkg; 48 register levels.
`timescale 1ns / 1ps
`default_nettype none
module tpne_norm
  import tpne_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire tpne_side_t          in_side,
  input  wire logic [SUMW-1:0]     in_sum,
  input  wire logic signed [31:0]  in_m [3],
  output logic                     out_vld_r,
  output tpne_side_t               out_side_r,
  output logic signed [15:0]       out_norm_r [3]
);

  // square root stages
  logic [SUMW-1:0]    sv_r  [0:SQRT_STEPS-1];
  logic [SUMW-1:0]    sr_r  [0:SQRT_STEPS-1];
  logic signed [31:0] sm_r  [0:SQRT_STEPS-1][3];
  tpne_side_t         ss_r  [0:SQRT_STEPS-1];
  logic               svl_r [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (60 - 2 * k);
    logic [SUMW-1:0]    v_in, r_in, v_nxt, r_nxt;
    logic signed [31:0] m_in [3];
    tpne_side_t         s_in;
    logic               vl_in;
    if (k == 0) begin : g_first
      assign v_in  = in_sum;
      assign r_in  = '0;
      assign m_in  = in_m;
      assign s_in  = in_side;
      assign vl_in = in_vld;
    end else begin : g_rest
      assign v_in  = sv_r[k-1];
      assign r_in  = sr_r[k-1];
      assign m_in  = sm_r[k-1];
      assign s_in  = ss_r[k-1];
      assign vl_in = svl_r[k-1];
    end
    always_comb begin
      if (v_in >= r_in + BIT) begin
        v_nxt = v_in - (r_in + BIT);
        r_nxt = (r_in >> 1) + BIT;
      end else begin
        v_nxt = v_in;
        r_nxt = r_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svl_r[k] <= 1'b0;
      end else if (en) begin
        svl_r[k] <= vl_in;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[k] <= v_nxt;
        sr_r[k] <= r_nxt;
        sm_r[k] <= m_in;
        ss_r[k] <= s_in;
      end
    end
  end

  // divider stages: index 0 is numerator setup, 1..QBITS one quotient bit each
  logic [DIVW-1:0]  drem_r [0:QBITS][3];
  logic [QBITS-1:0] dq_r   [0:QBITS][3];
  logic             dsg_r  [0:QBITS][3];
  logic [31:0]      dlen_r [0:QBITS];
  tpne_side_t       ds_r   [0:QBITS];
  logic             dvl_r  [0:QBITS];

  logic [31:0] len;
  assign len = sr_r[SQRT_STEPS-1][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvl_r[0] <= 1'b0;
    end else if (en) begin
      dvl_r[0] <= svl_r[SQRT_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        logic [31:0] a;
        a = sm_r[SQRT_STEPS-1][c][31] ? 32'(-sm_r[SQRT_STEPS-1][c])
                                      : 32'(sm_r[SQRT_STEPS-1][c]);
        drem_r[0][c] <= (DIVW'(a) << 14) + DIVW'(len >> 1);
        dq_r[0][c]   <= '0;
        dsg_r[0][c]  <= sm_r[SQRT_STEPS-1][c][31];
      end
      dlen_r[0] <= len;
      ds_r[0]   <= ss_r[SQRT_STEPS-1];
    end
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_div
    localparam int QB = QBITS - j;
    logic [DIVW-1:0] d;
    assign d = DIVW'(dlen_r[j-1]) << QB;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvl_r[j] <= 1'b0;
      end else if (en) begin
        dvl_r[j] <= dvl_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          if (drem_r[j-1][c] >= d) begin
            drem_r[j][c] <= drem_r[j-1][c] - d;
            dq_r[j][c]   <= dq_r[j-1][c] | (QBITS'(1) << QB);
          end else begin
            drem_r[j][c] <= drem_r[j-1][c];
            dq_r[j][c]   <= dq_r[j-1][c];
          end
          dsg_r[j][c] <= dsg_r[j-1][c];
        end
        dlen_r[j] <= dlen_r[j-1];
        ds_r[j]   <= ds_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dvl_r[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= ds_r[QBITS];
      for (int c = 0; c < 3; c++) begin
        if (!ds_r[QBITS].nvalid) begin
          out_norm_r[c] <= '0;
        end else if (dsg_r[QBITS][c]) begin
          out_norm_r[c] <= -$signed({1'b0, dq_r[QBITS][c]});
        end else begin
          out_norm_r[c] <= $signed({1'b0, dq_r[QBITS][c]});
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/torus_point_normal_eval_unit.sv]
// Torus point and normal evaluator. Each request carries one grid point (u, v)
// as binary angles and yields one result: the placed point in Q16.16 with
// saturation, and the placed unit normal in Q1.14. One point enters every clock
// while the output is not stalled; the pipeline runs through the CORDIC stages
// (one per iteration), the 31-stage square root and the 15-stage dividers of
// the normalizer. A stall at the output freezes the whole pipeline. The user
// must write registers through the cfg port only while no request is in flight;
// the block itself does not enforce this. Depends on tpne_pkg, tpne_cordic, tpne_norm.
`timescale 1ns / 1ps
`default_nettype none
`include "torus_point_normal_eval_unit_assert.svh"
module torus_point_normal_eval_unit
  import tpne_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [31:0]   in_tdata,   // u_angle[15:0], v_angle[31:16]
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // pos_x, pos_y, pos_z (32 each), norm_x, norm_y, norm_z (16 each)
  output logic [143:0]       out_tdata,
  output logic [1:0]         out_tuser,  // normal_valid[0], pos_saturated[1]
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_addr,
  input  wire logic [63:0]   cfg_wdata
);

  localparam int CL = ANGLE_BITS + 4;   // cordic register levels
  localparam int NV = CL + 13;

  logic        adv;
  logic [29:0] major_r, minor_r;
  logic [63:0] row_r [3];
  logic        nen_r;

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r  <= MAJOR_RST;
      minor_r  <= MINOR_RST;
      row_r[0] <= ROW_X_RST;
      row_r[1] <= ROW_Y_RST;
      row_r[2] <= ROW_Z_RST;
      nen_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MAJOR:   major_r  <= cfg_wdata[29:0];
        CFG_MINOR:   minor_r  <= cfg_wdata[29:0];
        CFG_ROW_X:   row_r[0] <= cfg_wdata;
        CFG_ROW_Y:   row_r[1] <= cfg_wdata;
        CFG_ROW_Z:   row_r[2] <= cfg_wdata;
        CFG_NORM_EN: nen_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- valid chain up to the normalizer
  logic [NV-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NV-2:0], in_tvalid};
    end
  end

  // ---------------- sin/cos
  logic signed [SCW-1:0] su, cu, sv, cv;
  tpne_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cord_u (
    .clk(clk), .en(adv), .angle(in_tdata[15:0]), .sin_r(su), .cos_r(cu)
  );
  tpne_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cord_v (
    .clk(clk), .en(adv), .angle(in_tdata[31:16]), .sin_r(sv), .cos_r(cv)
  );

  // ---------------- T1: r*cos v, r*sin v
  logic signed [64:0]     prc_nxt, prs_nxt;
  logic signed [RW-1:0]   rcv1_r, h1_r;
  logic signed [SCW-1:0]  su1_r, cu1_r;
  always_comb begin
    prc_nxt = $signed({1'b0, minor_r}) * cv;
    prs_nxt = $signed({1'b0, minor_r}) * sv;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rcv1_r <= RW'((prc_nxt + 65'sd536870912) >>> 30);
      h1_r   <= RW'((prs_nxt + 65'sd536870912) >>> 30);
      su1_r  <= su;
      cu1_r  <= cu;
    end
  end

  // ---------------- T2: rho, h*cos u, h*sin u
  logic signed [66:0]    phc_nxt, phs_nxt;
  logic signed [RHW-1:0] rho2_r;
  logic signed [PW-1:0]  hc2_r, hs2_r;
  logic signed [RW-1:0]  rcv2_r, h2_r;
  logic signed [SCW-1:0] su2_r, cu2_r;
  always_comb begin
    phc_nxt = h1_r * cu1_r;
    phs_nxt = h1_r * su1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rho2_r <= $signed({4'b0000, major_r}) + RHW'(rcv1_r);
      hc2_r  <= PW'((phc_nxt + 67'sd536870912) >>> 30);
      hs2_r  <= PW'((phs_nxt + 67'sd536870912) >>> 30);
      rcv2_r <= rcv1_r;
      h2_r   <= h1_r;
      su2_r  <= su1_r;
      cu2_r  <= cu1_r;
    end
  end

  // ---------------- T3: rho*cos u, rho*sin u
  logic signed [67:0]   ppx_nxt, ppy_nxt;
  logic signed [PW-1:0] px3_r, py3_r, pz3_r, hc3_r, hs3_r;
  logic signed [RW-1:0] rcv3_r;
  always_comb begin
    ppx_nxt = rho2_r * cu2_r;
    ppy_nxt = rho2_r * su2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      px3_r  <= PW'((ppx_nxt + 68'sd536870912) >>> 30);
      py3_r  <= PW'((ppy_nxt + 68'sd536870912) >>> 30);
      pz3_r  <= PW'(h2_r);
      hc3_r  <= hc2_r;
      hs3_r  <= hs2_r;
      rcv3_r <= rcv2_r;
    end
  end

  // ---------------- T4: placement and gradient cross products
  logic signed [50:0]   pp4_r [3][3];
  logic signed [XW-1:0] cxr4_r, cyr4_r, cyh4_r, cxh4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        pp4_r[r][0] <= 51'(coef(row_r[r], 0)) * 51'(px3_r);
        pp4_r[r][1] <= 51'(coef(row_r[r], 1)) * 51'(py3_r);
        pp4_r[r][2] <= 51'(coef(row_r[r], 2)) * 51'(pz3_r);
      end
      cxr4_r <= XW'(px3_r) * XW'(rcv3_r);
      cyr4_r <= XW'(py3_r) * XW'(rcv3_r);
      cyh4_r <= XW'(py3_r) * XW'(hs3_r);
      cxh4_r <= XW'(px3_r) * XW'(hc3_r);
    end
  end

  // ---------------- T5: placement sums with clamp, raw normal
  tpne_side_t           side5_nxt, side5_r;
  logic signed [31:0]   pos_nxt [3];
  logic                 sat_nxt;
  logic signed [NW-1:0] n5_r [3];
  logic signed [XW:0]   negy, negx;
  always_comb begin
    sat_nxt = 1'b0;
    for (int r = 0; r < 3; r++) begin
      logic signed [52:0] acc;
      logic signed [39:0] v;
      acc = 53'(pp4_r[r][0]) + 53'(pp4_r[r][1]) + 53'(pp4_r[r][2]);
      v = 40'((acc + 53'sd8192) >>> 14) + 40'($signed({coef(row_r[r], 3), 16'h0000}));
      if (v > 40'sd2147483647) begin
        pos_nxt[r] = 32'sh7FFF_FFFF;
        sat_nxt = 1'b1;
      end else if (v < -40'sd2147483648) begin
        pos_nxt[r] = 32'sh8000_0000;
        sat_nxt = 1'b1;
      end else begin
        pos_nxt[r] = 32'(v);
      end
    end
    side5_nxt.pos_x  = pos_nxt[0];
    side5_nxt.pos_y  = pos_nxt[1];
    side5_nxt.pos_z  = pos_nxt[2];
    side5_nxt.sat    = sat_nxt;
    side5_nxt.nvalid = 1'b0;
    negy = -(XW+1)'(cyr4_r);
    negx = -(XW+1)'(cxh4_r);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      side5_r <= side5_nxt;
      n5_r[0] <= NW'(cxr4_r >>> 24);
      n5_r[1] <= NW'(-(negy >>> 24));
      n5_r[2] <= NW'((cyh4_r >>> 24) - (negx >>> 24));
    end
  end

  // ---------------- T6: rotation products
  logic signed [57:0] rp6_r [3][3];
  tpne_side_t         side6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          rp6_r[r][c] <= 58'(coef(row_r[r], c)) * 58'(n5_r[c]);
        end
      end
      side6_r <= side5_r;
    end
  end

  // ---------------- T7: rotated normal
  logic signed [MW-1:0] m7_r [3];
  tpne_side_t           side7_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        m7_r[r] <= MW'(rp6_r[r][0]) + MW'(rp6_r[r][1]) + MW'(rp6_r[r][2]);
      end
      side7_r <= side6_r;
    end
  end

  // ---------------- T8: OR of magnitudes (same leading one as the max)
  logic [MW-1:0]        or_nxt, or8_r;
  logic signed [MW-1:0] m8_r [3];
  tpne_side_t           side8_r;
  always_comb begin
    or_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      or_nxt = or_nxt | (m7_r[r][MW-1] ? MW'(-m7_r[r]) : MW'(m7_r[r]));
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      or8_r   <= or_nxt;
      m8_r    <= m7_r;
      side8_r <= side7_r;
    end
  end

  // ---------------- T9: leading byte
  logic [63:0]          orpad;
  logic [2:0]           grp_nxt, grp9_r;
  logic [7:0]           byte_nxt, byte9_r;
  logic signed [MW-1:0] m9_r [3];
  tpne_side_t           side9_r;
  assign orpad = {{(64 - MW){1'b0}}, or8_r};
  always_comb begin
    grp_nxt  = '0;
    byte_nxt = '0;
    for (int g = 0; g < 8; g++) begin
      if (orpad[g*8 +: 8] != 8'h00) begin
        grp_nxt  = 3'(g);
        byte_nxt = orpad[g*8 +: 8];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      grp9_r  <= grp_nxt;
      byte9_r <= byte_nxt;
      m9_r    <= m8_r;
      side9_r <= side8_r;
    end
  end

  // ---------------- T10: leading bit, shift amount
  logic [2:0]           bit_nxt;
  logic [5:0]           lpos;
  logic                 rdir10_r, any10_r;
  logic [4:0]           sh10_r;
  logic signed [MW-1:0] m10_r [3];
  tpne_side_t           side10_r;
  always_comb begin
    bit_nxt = '0;
    for (int b = 0; b < 8; b++) begin
      if (byte9_r[b]) bit_nxt = 3'(b);
    end
    lpos = {grp9_r, bit_nxt};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rdir10_r <= lpos > 6'(NORM_MSB);
      sh10_r   <= (lpos > 6'(NORM_MSB)) ? 5'(lpos - 6'(NORM_MSB)) : 5'(6'(NORM_MSB) - lpos);
      any10_r  <= byte9_r != 8'h00;
      m10_r    <= m9_r;
      side10_r <= side9_r;
    end
  end

  // ---------------- T11: normalize to [2^29, 2^30)
  logic signed [31:0] mn11_r [3];
  tpne_side_t         side11_nxt, side11_r;
  always_comb begin
    side11_nxt        = side10_r;
    side11_nxt.nvalid = nen_r && any10_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        mn11_r[r] <= rdir10_r ? 32'(m10_r[r] >>> sh10_r) : 32'(m10_r[r] <<< sh10_r);
      end
      side11_r <= side11_nxt;
    end
  end

  // ---------------- T12: squares
  logic [SUMW-2:0]    sq12_r [3];
  logic signed [31:0] mn12_r [3];
  tpne_side_t         side12_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        logic signed [63:0] sq;
        sq = mn11_r[r] * mn11_r[r];
        sq12_r[r] <= sq[SUMW-2:0];
      end
      mn12_r   <= mn11_r;
      side12_r <= side11_r;
    end
  end

  // ---------------- T13: sum of squares
  logic [SUMW-1:0]    sum13_r;
  logic signed [31:0] mn13_r [3];
  tpne_side_t         side13_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum13_r  <= SUMW'(sq12_r[0]) + SUMW'(sq12_r[1]) + SUMW'(sq12_r[2]);
      mn13_r   <= mn12_r;
      side13_r <= side12_r;
    end
  end

  // ---------------- normalizer, its last stage is the output register
  tpne_side_t         oside;
  logic signed [15:0] onorm [3];
  tpne_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(vld_r[NV-1]), .in_side(side13_r), .in_sum(sum13_r), .in_m(mn13_r),
    .out_vld_r(out_tvalid), .out_side_r(oside), .out_norm_r(onorm)
  );

  assign out_tdata = {onorm[2], onorm[1], onorm[0], oside.pos_z, oside.pos_y, oside.pos_x};
  assign out_tuser = {oside.sat, oside.nvalid};

  // ---------------- checks
  `TPNE_ASSERT_NOW(a_stall_blocks_in, out_tvalid && !out_tready, !in_tready,
    "input taken while output stalled")
  `TPNE_ASSERT_NEXT(a_stall_freezes, out_tvalid && !out_tready, $stable(vld_r),
    "pipeline moved during stall")
  `TPNE_ASSERT_NOW(a_invalid_zero, out_tvalid && !out_tuser[0], out_tdata[143:96] == 48'h0,
    "nonzero normal flagged invalid")
  `TPNE_ASSERT_NOW(a_valid_nonzero, out_tvalid && out_tuser[0],
    out_tdata[111:96] != 16'h0 || out_tdata[127:112] != 16'h0 || out_tdata[143:128] != 16'h0,
    "valid normal is zero")

endmodule
`default_nettype wire
